// ----- rtl/sba_pkg.sv -----
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types, register indexes, behavior codes and constant speeds for the
// subsumption behavior arbiter.
// ----------------------------------------------------------------------------
package sba_pkg;

    // number of priority slots held in the slot register
    localparam int MAX_SLOTS = 8;
    localparam int SLOT_W    = 3;
    localparam int CODE_W    = 4;

    // configuration register indexes
    localparam logic [2:0] CFG_PRIORITY_SLOTS     = 3'd0;
    localparam logic [2:0] CFG_SLOTS_IN_USE       = 3'd1;
    localparam logic [2:0] CFG_NEAR_THRESHOLD     = 3'd2;
    localparam logic [2:0] CFG_GRADIENT_THRESHOLD = 3'd3;
    localparam logic [2:0] CFG_STRAIGHT_SPEED     = 3'd4;
    localparam logic [2:0] CFG_ARC_SLOW_SPEED     = 3'd5;
    localparam logic [2:0] CFG_ARC_FAST_SPEED     = 3'd6;

    // behavior codes, catalog order
    localparam logic [3:0] BEH_ESCAPE_FRONT    = 4'd1;
    localparam logic [3:0] BEH_ESCAPE_BACK     = 4'd2;
    localparam logic [3:0] BEH_AVOID_OBJECT    = 4'd3;
    localparam logic [3:0] BEH_APPROACH_OBJECT = 4'd4;
    localparam logic [3:0] BEH_AVOID_LIGHT     = 4'd5;
    localparam logic [3:0] BEH_APPROACH_LIGHT  = 4'd6;
    localparam logic [3:0] BEH_CRUISE_STRAIGHT = 4'd7;
    localparam logic [3:0] BEH_CRUISE_ARC      = 4'd8;

    // duration codes
    typedef enum logic [2:0] {
        DUR_HALT   = 3'd0,
        DUR_SHORT  = 3'd1,
        DUR_LONG   = 3'd2,
        DUR_ESCAPE = 3'd3,
        DUR_CRUISE = 3'd4
    } sba_dur_t;

    // fixed wheel speeds
    localparam logic signed [7:0] SPD_ZERO     = 8'sd0;
    localparam logic signed [7:0] SPD_FULL_FWD = 8'sd100;
    localparam logic signed [7:0] SPD_FULL_REV = -8'sd100;
    localparam logic signed [7:0] SPD_TURN_FWD = 8'sd40;
    localparam logic signed [7:0] SPD_TURN_REV = -8'sd40;
    localparam logic signed [7:0] SPD_VEER_HI  = 8'sd60;
    localparam logic signed [7:0] SPD_VEER_LO  = 8'sd40;
    localparam logic [6:0]        SPD_LIMIT    = 7'd100;

    localparam logic signed [3:0] SLOT_NONE = -4'sd1;

    // one control tick
    typedef struct packed {
        logic [9:0]  prox_right;
        logic [9:0]  prox_left;
        logic [6:0]  light_right;
        logic [6:0]  light_left;
        logic        bump_front_left;
        logic        bump_front_right;
        logic        bump_back_left;
        logic        bump_back_right;
        logic [31:0] now_ms;
        logic        coin;
        logic [15:0] hold_ms;
    } sba_item_t;

    // one arbitration result
    typedef struct packed {
        logic signed [7:0] left_speed;
        logic signed [7:0] right_speed;
        logic [2:0]        duration_code;
        logic signed [3:0] fired_slot;
    } sba_result_t;

    // configuration registers
    typedef struct packed {
        logic [31:0] priority_slots;
        logic [3:0]  slots_in_use;
        logic [9:0]  near_threshold;
        logic [6:0]  gradient_threshold;
        logic [6:0]  straight_speed;
        logic [6:0]  arc_slow_speed;
        logic [6:0]  arc_fast_speed;
    } sba_cfg_t;

    // clamp a speed register to 100 percent
    function automatic logic signed [7:0] sat100(input logic [6:0] v);
        logic [6:0] c;
        begin
            c = (v > SPD_LIMIT) ? SPD_LIMIT : v;
            return $signed({1'b0, c});
        end
    endfunction

endpackage

// ----- rtl/sba_in_stage.sv -----
// ----------------------------------------------------------------------------
// sba_in_stage
// Input register of the arbiter: captures one transaction and holds it until
// the arbitration stage takes it.
// ----------------------------------------------------------------------------
module sba_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sba_pkg::sba_item_t in_item,
    input  logic              take,
    output logic              item_valid,
    output sba_pkg::sba_item_t item
);
    import sba_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    sba_item_t item_reg;

    // free when empty or when the held item leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- rtl/sba_arbiter.sv -----
// ----------------------------------------------------------------------------
// sba_arbiter
// Guard evaluation, priority scan and result selection for one tick, plus
// the cruise-arc direction and deadline state.
// ----------------------------------------------------------------------------
module sba_arbiter (
    input  logic                clk,
    input  logic                rst_n,
    input  sba_pkg::sba_item_t  item,
    input  sba_pkg::sba_cfg_t   cfg,
    input  logic                advance,
    output sba_pkg::sba_result_t result
);
    import sba_pkg::*;

    logic        arc_left_reg;
    logic        arc_left_next;
    logic [31:0] arc_deadline_reg;
    logic [31:0] arc_deadline_next;

    logic              pf_l, pf_r, pb_l, pb_r;
    logic              near_r, near_l;
    logic signed [8:0] grad;
    logic signed [8:0] agrad;
    logic signed [8:0] thr;
    logic              light;
    logic              grad_pos;
    logic signed [7:0] cs, ai, ao;
    logic [3:0]        n_slots;
    logic [15:0]       guard_by_code;
    logic              found;
    logic [SLOT_W-1:0] win_slot;
    logic [CODE_W-1:0] win_code;
    logic [CODE_W-1:0] code_i;
    logic              redraw;
    logic              arc_left_eff;
    logic              arc_update;
    sba_result_t       res;

    // sensor conditions
    always_comb
    begin
        pf_l     = !item.bump_front_left;
        pf_r     = !item.bump_front_right;
        pb_l     = !item.bump_back_left;
        pb_r     = !item.bump_back_right;
        near_r   = item.prox_right <= cfg.near_threshold;
        near_l   = item.prox_left <= cfg.near_threshold;
        grad     = $signed({2'b00, item.light_right}) - $signed({2'b00, item.light_left});
        agrad    = grad[8] ? -grad : grad;
        thr      = $signed({2'b00, cfg.gradient_threshold});
        light    = agrad >= thr;
        grad_pos = grad >= thr;
        cs       = sat100(cfg.straight_speed);
        ai       = sat100(cfg.arc_slow_speed);
        ao       = sat100(cfg.arc_fast_speed);
        n_slots  = (cfg.slots_in_use > 4'(MAX_SLOTS)) ? 4'(MAX_SLOTS) : cfg.slots_in_use;
    end

    // guard per behavior code, unknown codes never fire
    always_comb
    begin
        guard_by_code                      = '0;
        guard_by_code[BEH_ESCAPE_FRONT]    = pf_l || pf_r;
        guard_by_code[BEH_ESCAPE_BACK]     = pb_l || pb_r;
        guard_by_code[BEH_AVOID_OBJECT]    = near_r || near_l;
        guard_by_code[BEH_APPROACH_OBJECT] = near_r || near_l;
        guard_by_code[BEH_AVOID_LIGHT]     = light;
        guard_by_code[BEH_APPROACH_LIGHT]  = light;
        guard_by_code[BEH_CRUISE_STRAIGHT] = 1'b1;
        guard_by_code[BEH_CRUISE_ARC]      = 1'b1;
    end

    // priority scan, slot 0 first
    always_comb
    begin
        found    = 1'b0;
        win_slot = '0;
        win_code = '0;
        code_i   = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            code_i = cfg.priority_slots[CODE_W*i +: CODE_W];
            if (!found && (4'(i) < n_slots) && guard_by_code[code_i])
            begin
                found    = 1'b1;
                win_slot = SLOT_W'(i);
                win_code = code_i;
            end
        end
    end

    // arc direction redraw once the deadline has passed
    always_comb
    begin
        redraw       = item.now_ms >= arc_deadline_reg;
        arc_left_eff = redraw ? !item.coin : arc_left_reg;
        arc_update   = found && (win_code == BEH_CRUISE_ARC) && redraw;
        arc_left_next     = arc_left_reg;
        arc_deadline_next = arc_deadline_reg;
        if (advance && arc_update)
        begin
            arc_left_next     = !item.coin;
            arc_deadline_next = item.now_ms + {16'h0000, item.hold_ms};
        end
    end

    // winner's wheel command
    always_comb
    begin
        res.left_speed    = SPD_ZERO;
        res.right_speed   = SPD_ZERO;
        res.duration_code = DUR_HALT;
        res.fired_slot    = SLOT_NONE;
        if (found)
        begin
            res.fired_slot = $signed({1'b0, win_slot});
            unique case (win_code)
                BEH_ESCAPE_FRONT:
                begin
                    res.duration_code = DUR_ESCAPE;
                    if (pf_l && pf_r)
                    begin
                        res.left_speed  = SPD_FULL_REV;
                        res.right_speed = SPD_FULL_REV;
                    end
                    else if (pf_l)
                    begin
                        res.left_speed  = SPD_FULL_REV;
                        res.right_speed = SPD_FULL_FWD;
                    end
                    else
                    begin
                        res.left_speed  = SPD_FULL_FWD;
                        res.right_speed = SPD_FULL_REV;
                    end
                end
                BEH_ESCAPE_BACK:
                begin
                    res.duration_code = DUR_ESCAPE;
                    res.left_speed    = SPD_FULL_FWD;
                    res.right_speed   = SPD_FULL_FWD;
                end
                BEH_AVOID_OBJECT:
                begin
                    res.duration_code = DUR_LONG;
                    res.left_speed    = near_r ? SPD_TURN_REV : SPD_TURN_FWD;
                    res.right_speed   = near_r ? SPD_TURN_FWD : SPD_TURN_REV;
                end
                BEH_APPROACH_OBJECT:
                begin
                    res.duration_code = DUR_SHORT;
                    if (near_r && near_l)
                    begin
                        res.left_speed  = cs;
                        res.right_speed = cs;
                    end
                    else if (near_r)
                    begin
                        res.left_speed  = SPD_VEER_HI;
                        res.right_speed = SPD_VEER_LO;
                    end
                    else
                    begin
                        res.left_speed  = SPD_VEER_LO;
                        res.right_speed = SPD_VEER_HI;
                    end
                end
                BEH_AVOID_LIGHT:
                begin
                    res.duration_code = DUR_SHORT;
                    res.left_speed    = grad_pos ? SPD_TURN_FWD : SPD_TURN_REV;
                    res.right_speed   = grad_pos ? SPD_TURN_REV : SPD_TURN_FWD;
                end
                BEH_APPROACH_LIGHT:
                begin
                    res.duration_code = DUR_LONG;
                    res.left_speed    = grad_pos ? SPD_TURN_REV : SPD_TURN_FWD;
                    res.right_speed   = grad_pos ? SPD_TURN_FWD : SPD_TURN_REV;
                end
                BEH_CRUISE_STRAIGHT:
                begin
                    res.duration_code = DUR_CRUISE;
                    res.left_speed    = cs;
                    res.right_speed   = cs;
                end
                BEH_CRUISE_ARC:
                begin
                    res.duration_code = DUR_CRUISE;
                    res.left_speed    = arc_left_eff ? ai : ao;
                    res.right_speed   = arc_left_eff ? ao : ai;
                end
                default:
                begin
                    res.duration_code = DUR_HALT;
                end
            endcase
        end
    end

    assign result = res;

    // arc state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arc_left_reg     <= 1'b0;
            arc_deadline_reg <= '0;
        end
        else
        begin
            arc_left_reg     <= arc_left_next;
            arc_deadline_reg <= arc_deadline_next;
        end
    end

endmodule

// ----- rtl/subsumption_behavior_arbiter.sv -----
// ----------------------------------------------------------------------------
// subsumption_behavior_arbiter
// Priority arbiter over up to eight robot behaviors for one control tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one control tick per
//   transaction: proximity, light and bumper readings, time, coin and hold.
//   Output channel (out_valid / out_ready) returns exactly one transaction per
//   tick: wheel speeds, duration code and the winning slot (-1 for halt).
//   From input acceptance to out_valid there is one input register, then
//   guards, priority scan and result select feed the output register.
//   Throughput is one tick per cycle while out_ready holds; the input register
//   takes a new tick while a finished result waits in the output register.
//   If the receiver stalls, the output register holds, the input register
//   fills and in_ready drops until out_ready returns.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   the user makes them only while the block is idle, which the block does not
//   enforce; index 7 is ignored. Reset empties both stages, loads the register
//   defaults and clears the cruise-arc direction and deadline.
// ----------------------------------------------------------------------------
module subsumption_behavior_arbiter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [9:0]        prox_right,
    input  logic [9:0]        prox_left,
    input  logic [6:0]        light_right,
    input  logic [6:0]        light_left,
    input  logic              bump_front_left,
    input  logic              bump_front_right,
    input  logic              bump_back_left,
    input  logic              bump_back_right,
    input  logic [31:0]       now_ms,
    input  logic              coin,
    input  logic [15:0]       hold_ms,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [7:0] left_speed,
    output logic signed [7:0] right_speed,
    output logic [2:0]        duration_code,
    output logic signed [3:0] fired_slot
);
    import sba_pkg::*;

    sba_cfg_t    cfg_reg;
    sba_item_t   in_item;
    sba_item_t   item;
    logic        item_valid;
    logic        advance;
    sba_result_t result;
    sba_result_t res_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.priority_slots     <= '0;
            cfg_reg.slots_in_use       <= '0;
            cfg_reg.near_threshold     <= 10'd35;
            cfg_reg.gradient_threshold <= 7'd15;
            cfg_reg.straight_speed     <= 7'd50;
            cfg_reg.arc_slow_speed     <= 7'd30;
            cfg_reg.arc_fast_speed     <= 7'd50;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRIORITY_SLOTS:     cfg_reg.priority_slots     <= cfg_data;
                CFG_SLOTS_IN_USE:       cfg_reg.slots_in_use       <= cfg_data[3:0];
                CFG_NEAR_THRESHOLD:     cfg_reg.near_threshold     <= cfg_data[9:0];
                CFG_GRADIENT_THRESHOLD: cfg_reg.gradient_threshold <= cfg_data[6:0];
                CFG_STRAIGHT_SPEED:     cfg_reg.straight_speed     <= cfg_data[6:0];
                CFG_ARC_SLOW_SPEED:     cfg_reg.arc_slow_speed     <= cfg_data[6:0];
                CFG_ARC_FAST_SPEED:     cfg_reg.arc_fast_speed     <= cfg_data[6:0];
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // pack the input transaction
    always_comb
    begin
        in_item.prox_right       = prox_right;
        in_item.prox_left        = prox_left;
        in_item.light_right      = light_right;
        in_item.light_left       = light_left;
        in_item.bump_front_left  = bump_front_left;
        in_item.bump_front_right = bump_front_right;
        in_item.bump_back_left   = bump_back_left;
        in_item.bump_back_right  = bump_back_right;
        in_item.now_ms           = now_ms;
        in_item.coin             = coin;
        in_item.hold_ms          = hold_ms;
    end

    // tick moves on when the output register is free or being emptied
    assign advance = item_valid && (!out_valid_reg || out_ready);

    sba_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sba_arbiter u_arbiter (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cfg     (cfg_reg),
        .advance (advance),
        .result  (result)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_speed    = res_reg.left_speed;
    assign right_speed   = res_reg.right_speed;
    assign duration_code = res_reg.duration_code;
    assign fired_slot    = res_reg.fired_slot;

endmodule
